>>> sv/cctc_pkg.sv
// ----------------------------------------------------------------------------
// Crossing classifier package
// Shared widths, register indices, reset values and result codes.
// ----------------------------------------------------------------------------
package cctc_pkg;

   localparam int LIMB_W     = 32;
   localparam int DLIMB_W    = 2 * LIMB_W;
   localparam int QLIMB_W    = 4 * LIMB_W;
   localparam int CFG_W      = 32;
   localparam int RHS_W      = CFG_W + QLIMB_W;
   localparam int RHS_HI_W   = RHS_W - DLIMB_W;
   localparam int NUM_STAGES = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int PLACE_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NULL_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARALLEL_TOL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVATURE_TOL = 2'd2;

   localparam logic [CFG_W-1:0] NULL_LIMIT_RESET    = 32'd0;
   localparam logic [CFG_W-1:0] PARALLEL_TOL_RESET  = 32'd1845;
   localparam logic [CFG_W-1:0] CURVATURE_TOL_RESET = 32'd43;

   localparam logic [PLACE_W-1:0] PLACE_END      = 2'd2;
   localparam logic [PLACE_W-1:0] PLACE_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      KIND_IN,
      KIND_OUT,
      KIND_TOUCH,
      KIND_UNDECIDED
   } kind_type;

   typedef enum logic [1:0] {
      SIT_INSIDE,
      SIT_OUTSIDE,
      SIT_UNKNOWN
   } situation_type;

endpackage

>>> sv/curve_crossing_transition_classifier.sv
// ----------------------------------------------------------------------------
// Curve crossing transition classifier
// A word accepted on req passes through the stage registers s1 to s8 before
// it appears on rsp.
// Throughput: one word per cycle; the eight-stage multiplier pipeline sets
// the latency, and stalls are absorbed stage by stage.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module curve_crossing_transition_classifier
   import cctc_pkg::*;
#(
   parameter int COMPONENT_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [PLACE_W-1:0]               req_position_a,
   input  logic signed [COMPONENT_BITS-1:0] req_tangent_a_x,
   input  logic signed [COMPONENT_BITS-1:0] req_tangent_a_y,
   input  logic signed [COMPONENT_BITS-1:0] req_normal_a_x,
   input  logic signed [COMPONENT_BITS-1:0] req_normal_a_y,
   input  logic [PLACE_W-1:0]               req_position_b,
   input  logic signed [COMPONENT_BITS-1:0] req_tangent_b_x,
   input  logic signed [COMPONENT_BITS-1:0] req_tangent_b_y,
   input  logic signed [COMPONENT_BITS-1:0] req_normal_b_x,
   input  logic signed [COMPONENT_BITS-1:0] req_normal_b_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind_a,
   output logic [1:0]                       rsp_situation_a,
   output logic [1:0]                       rsp_kind_b,
   output logic [1:0]                       rsp_situation_b,
   output logic                             rsp_opposite,
   output logic [PLACE_W-1:0]               rsp_place_a,
   output logic [PLACE_W-1:0]               rsp_place_b,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_W-1:0]           csr_index,
   input  logic [CFG_W-1:0]                 csr_data
);

   localparam int PROD_W     = 2 * COMPONENT_BITS;
   localparam int ACC_W      = PROD_W + 1;
   localparam int DIFF_W     = PROD_W + 2;
   localparam int NULL_CMP_W = (PROD_W > CFG_W) ? PROD_W : CFG_W;
   localparam int TOL_CMP_W  = (DIFF_W > CFG_W) ? DIFF_W : CFG_W;

   typedef logic signed [COMPONENT_BITS-1:0] comp_type;
   typedef logic signed [PROD_W-1:0]         prod_type;
   typedef logic [PROD_W-1:0]                mag_type;
   typedef logic signed [ACC_W-1:0]          acc_type;

   typedef struct packed {
      comp_type            tax, tay, nax, nay, tbx, tby, nbx, nby;
      prod_type            sq_tax, sq_tay, sq_nax, sq_nay;
      prod_type            sq_tbx, sq_tby, sq_nbx, sq_nby;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s1_type;

   typedef struct packed {
      comp_type            t1x, t1y, t2x, t2y, nax, nay, nbx, nby;
      mag_type             m1, m2;
      logic                curv_a, curv_b, decided;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s2_type;

   typedef struct packed {
      prod_type            pc1, pc2, pd1, pd2, pa1, pa2, pb1, pb2;
      logic [DLIMB_W-1:0]  mm0, mm1, mm2, mm3;
      logic                curv_a, curv_b, decided;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s3_type;

   typedef struct packed {
      acc_type             cr, va, vb;
      logic                dot_neg;
      logic [QLIMB_W-1:0]  m12;
      logic                curv_any, decided;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s4_type;

   typedef struct packed {
      mag_type                   cm;
      logic signed [DIFF_W-1:0]  d;
      logic [DLIMB_W-1:0]        tp0, tp1, tp2, tp3;
      logic                      cr_neg, dot_neg, curv_any, decided;
      logic [PLACE_W-1:0]        place_a, place_b;
   } s5_type;

   typedef struct packed {
      logic [DLIMB_W-1:0]  cp0, cp1, cp3;
      logic [RHS_W-1:0]    rhs;
      logic                side_known, d_neg, cr_neg, dot_neg, curv_any, decided;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s6_type;

   typedef struct packed {
      logic [QLIMB_W-1:0]  lhs;
      logic [RHS_HI_W-1:0] rhs_hi;
      logic                side_known, d_neg, cr_neg, dot_neg, curv_any, decided;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s7_type;

   typedef struct packed {
      kind_type            kind_a, kind_b;
      situation_type       sit_a, sit_b;
      logic                opposite;
      logic [PLACE_W-1:0]  place_a, place_b;
   } s8_type;

   logic [CFG_W-1:0] null_limit_ff, par_tol_ff, curv_tol_ff;

   logic [NUM_STAGES:1] valid_ff, valid_in, stage_ready;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_limit_ff <= NULL_LIMIT_RESET;
         par_tol_ff    <= PARALLEL_TOL_RESET;
         curv_tol_ff   <= CURVATURE_TOL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NULL_LIMIT:    null_limit_ff <= csr_data;
            CSR_PARALLEL_TOL:  par_tol_ff    <= csr_data;
            CSR_CURVATURE_TOL: curv_tol_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Each stage moves on when it is empty or the stage after it moves.
   always_comb begin
      stage_ready[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = stage_ready[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // Stage 1: squares of all components.
   always_comb begin
      s1_in.tax    = req_tangent_a_x;
      s1_in.tay    = req_tangent_a_y;
      s1_in.nax    = req_normal_a_x;
      s1_in.nay    = req_normal_a_y;
      s1_in.tbx    = req_tangent_b_x;
      s1_in.tby    = req_tangent_b_y;
      s1_in.nbx    = req_normal_b_x;
      s1_in.nby    = req_normal_b_y;
      s1_in.sq_tax = req_tangent_a_x * req_tangent_a_x;
      s1_in.sq_tay = req_tangent_a_y * req_tangent_a_y;
      s1_in.sq_nax = req_normal_a_x * req_normal_a_x;
      s1_in.sq_nay = req_normal_a_y * req_normal_a_y;
      s1_in.sq_tbx = req_tangent_b_x * req_tangent_b_x;
      s1_in.sq_tby = req_tangent_b_y * req_tangent_b_y;
      s1_in.sq_nbx = req_normal_b_x * req_normal_b_x;
      s1_in.sq_nby = req_normal_b_y * req_normal_b_y;
      s1_in.place_a = (req_position_a == PLACE_RESERVED) ? PLACE_END : req_position_a;
      s1_in.place_b = (req_position_b == PLACE_RESERVED) ? PLACE_END : req_position_b;
   end

   // Stage 2: squared magnitudes, null test and tangent replacement.
   always_comb begin
      mag_type sqm_ta, sqm_na, sqm_tb, sqm_nb;
      logic    null_ta, null_na, null_tb, null_nb;
      sqm_ta  = $unsigned(s1_ff.sq_tax) + $unsigned(s1_ff.sq_tay);
      sqm_na  = $unsigned(s1_ff.sq_nax) + $unsigned(s1_ff.sq_nay);
      sqm_tb  = $unsigned(s1_ff.sq_tbx) + $unsigned(s1_ff.sq_tby);
      sqm_nb  = $unsigned(s1_ff.sq_nbx) + $unsigned(s1_ff.sq_nby);
      null_ta = NULL_CMP_W'(sqm_ta) <= NULL_CMP_W'(null_limit_ff);
      null_na = NULL_CMP_W'(sqm_na) <= NULL_CMP_W'(null_limit_ff);
      null_tb = NULL_CMP_W'(sqm_tb) <= NULL_CMP_W'(null_limit_ff);
      null_nb = NULL_CMP_W'(sqm_nb) <= NULL_CMP_W'(null_limit_ff);

      s2_in.nax = s1_ff.nax;
      s2_in.nay = s1_ff.nay;
      s2_in.nbx = s1_ff.nbx;
      s2_in.nby = s1_ff.nby;
      s2_in.t1x = null_ta ? s1_ff.nax : s1_ff.tax;
      s2_in.t1y = null_ta ? s1_ff.nay : s1_ff.tay;
      s2_in.m1  = null_ta ? sqm_na : sqm_ta;
      s2_in.t2x = null_tb ? s1_ff.nbx : s1_ff.tbx;
      s2_in.t2y = null_tb ? s1_ff.nby : s1_ff.tby;
      s2_in.m2  = null_tb ? sqm_nb : sqm_tb;
      s2_in.curv_a  = !null_ta;
      s2_in.curv_b  = !null_tb;
      s2_in.decided = !(null_ta && null_na) && !(null_tb && null_nb);
      s2_in.place_a = s1_ff.place_a;
      s2_in.place_b = s1_ff.place_b;
   end

   // Stage 3: cross, dot and curvature products; partial products of m1 * m2.
   always_comb begin
      logic [DLIMB_W-1:0] m1e, m2e;
      m1e = DLIMB_W'(s2_ff.m1);
      m2e = DLIMB_W'(s2_ff.m2);
      s3_in.pc1 = s2_ff.t1x * s2_ff.t2y;
      s3_in.pc2 = s2_ff.t1y * s2_ff.t2x;
      s3_in.pd1 = s2_ff.t1x * s2_ff.t2x;
      s3_in.pd2 = s2_ff.t1y * s2_ff.t2y;
      s3_in.pa1 = s2_ff.t1x * s2_ff.nay;
      s3_in.pa2 = s2_ff.t1y * s2_ff.nax;
      s3_in.pb1 = s2_ff.t1x * s2_ff.nby;
      s3_in.pb2 = s2_ff.t1y * s2_ff.nbx;
      s3_in.mm0 = m1e[LIMB_W-1:0] * m2e[LIMB_W-1:0];
      s3_in.mm1 = m1e[LIMB_W-1:0] * m2e[DLIMB_W-1:LIMB_W];
      s3_in.mm2 = m1e[DLIMB_W-1:LIMB_W] * m2e[LIMB_W-1:0];
      s3_in.mm3 = m1e[DLIMB_W-1:LIMB_W] * m2e[DLIMB_W-1:LIMB_W];
      s3_in.curv_a  = s2_ff.curv_a;
      s3_in.curv_b  = s2_ff.curv_b;
      s3_in.decided = s2_ff.decided;
      s3_in.place_a = s2_ff.place_a;
      s3_in.place_b = s2_ff.place_b;
   end

   // Stage 4: sums of products.
   always_comb begin
      acc_type dot;
      s4_in.cr = ACC_W'(s3_ff.pc1) - ACC_W'(s3_ff.pc2);
      dot      = ACC_W'(s3_ff.pd1) + ACC_W'(s3_ff.pd2);
      s4_in.dot_neg = dot[ACC_W-1];
      s4_in.va = s3_ff.curv_a ? ACC_W'(s3_ff.pa1) - ACC_W'(s3_ff.pa2) : '0;
      s4_in.vb = s3_ff.curv_b ? ACC_W'(s3_ff.pb1) - ACC_W'(s3_ff.pb2) : '0;
      s4_in.m12 = QLIMB_W'(s3_ff.mm0)
                + (QLIMB_W'(s3_ff.mm1) << LIMB_W)
                + (QLIMB_W'(s3_ff.mm2) << LIMB_W)
                + (QLIMB_W'(s3_ff.mm3) << DLIMB_W);
      s4_in.curv_any = s3_ff.curv_a || s3_ff.curv_b;
      s4_in.decided  = s3_ff.decided;
      s4_in.place_a  = s3_ff.place_a;
      s4_in.place_b  = s3_ff.place_b;
   end

   // Stage 5: cross magnitude, curvature difference, tolerance partial products.
   always_comb begin
      logic [ACC_W-1:0] cr_mag;
      cr_mag = s4_ff.cr[ACC_W-1] ? -s4_ff.cr : s4_ff.cr;
      s5_in.cm  = cr_mag[PROD_W-1:0];
      s5_in.d   = DIFF_W'(s4_ff.va) - DIFF_W'(s4_ff.vb);
      s5_in.tp0 = par_tol_ff * s4_ff.m12[0*LIMB_W +: LIMB_W];
      s5_in.tp1 = par_tol_ff * s4_ff.m12[1*LIMB_W +: LIMB_W];
      s5_in.tp2 = par_tol_ff * s4_ff.m12[2*LIMB_W +: LIMB_W];
      s5_in.tp3 = par_tol_ff * s4_ff.m12[3*LIMB_W +: LIMB_W];
      s5_in.cr_neg   = s4_ff.cr[ACC_W-1];
      s5_in.dot_neg  = s4_ff.dot_neg;
      s5_in.curv_any = s4_ff.curv_any;
      s5_in.decided  = s4_ff.decided;
      s5_in.place_a  = s4_ff.place_a;
      s5_in.place_b  = s4_ff.place_b;
   end

   // Stage 6: partial products of the squared cross, tolerance product sum,
   // curvature side test.
   always_comb begin
      logic [DLIMB_W-1:0] cme;
      logic [DIFF_W-1:0]  ad;
      logic               d_neg;
      cme   = DLIMB_W'(s5_ff.cm);
      d_neg = s5_ff.d[DIFF_W-1];
      ad    = d_neg ? -s5_ff.d : s5_ff.d;
      s6_in.cp0 = cme[LIMB_W-1:0] * cme[LIMB_W-1:0];
      s6_in.cp1 = cme[LIMB_W-1:0] * cme[DLIMB_W-1:LIMB_W];
      s6_in.cp3 = cme[DLIMB_W-1:LIMB_W] * cme[DLIMB_W-1:LIMB_W];
      s6_in.rhs = RHS_W'(s5_ff.tp0)
                + (RHS_W'(s5_ff.tp1) << LIMB_W)
                + (RHS_W'(s5_ff.tp2) << DLIMB_W)
                + (RHS_W'(s5_ff.tp3) << (3 * LIMB_W));
      s6_in.side_known = TOL_CMP_W'(ad) > TOL_CMP_W'(curv_tol_ff);
      s6_in.d_neg      = d_neg;
      s6_in.cr_neg     = s5_ff.cr_neg;
      s6_in.dot_neg    = s5_ff.dot_neg;
      s6_in.curv_any   = s5_ff.curv_any;
      s6_in.decided    = s5_ff.decided;
      s6_in.place_a    = s5_ff.place_a;
      s6_in.place_b    = s5_ff.place_b;
   end

   // Stage 7: squared cross and the scaled tolerance bound.
   always_comb begin
      s7_in.lhs = QLIMB_W'(s6_ff.cp0)
                + (QLIMB_W'(s6_ff.cp1) << (LIMB_W + 1))
                + (QLIMB_W'(s6_ff.cp3) << DLIMB_W);
      s7_in.rhs_hi     = s6_ff.rhs[RHS_W-1:DLIMB_W];
      s7_in.side_known = s6_ff.side_known;
      s7_in.d_neg      = s6_ff.d_neg;
      s7_in.cr_neg     = s6_ff.cr_neg;
      s7_in.dot_neg    = s6_ff.dot_neg;
      s7_in.curv_any   = s6_ff.curv_any;
      s7_in.decided    = s6_ff.decided;
      s7_in.place_a    = s6_ff.place_a;
      s7_in.place_b    = s6_ff.place_b;
   end

   // Stage 8: parallel test and classification.
   always_comb begin
      logic parallel;
      parallel = s7_ff.lhs <= QLIMB_W'(s7_ff.rhs_hi);
      s8_in.kind_a   = KIND_UNDECIDED;
      s8_in.kind_b   = KIND_UNDECIDED;
      s8_in.sit_a    = SIT_UNKNOWN;
      s8_in.sit_b    = SIT_UNKNOWN;
      s8_in.opposite = 1'b0;
      s8_in.place_a  = s7_ff.place_a;
      s8_in.place_b  = s7_ff.place_b;
      if (s7_ff.decided) begin
         if (parallel) begin
            s8_in.kind_a   = KIND_TOUCH;
            s8_in.kind_b   = KIND_TOUCH;
            s8_in.opposite = s7_ff.dot_neg;
            if (s7_ff.curv_any && s7_ff.side_known) begin
               if (s7_ff.d_neg) begin
                  s8_in.sit_b = SIT_INSIDE;
                  s8_in.sit_a = s7_ff.dot_neg ? SIT_INSIDE : SIT_OUTSIDE;
               end else begin
                  s8_in.sit_b = SIT_OUTSIDE;
                  s8_in.sit_a = s7_ff.dot_neg ? SIT_OUTSIDE : SIT_INSIDE;
               end
            end
         end else if (s7_ff.cr_neg) begin
            s8_in.kind_a = KIND_IN;
            s8_in.kind_b = KIND_OUT;
         end else begin
            s8_in.kind_a = KIND_OUT;
            s8_in.kind_b = KIND_IN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) s1_ff <= s1_in;
      if (stage_ready[2]) s2_ff <= s2_in;
      if (stage_ready[3]) s3_ff <= s3_in;
      if (stage_ready[4]) s4_ff <= s4_in;
      if (stage_ready[5]) s5_ff <= s5_in;
      if (stage_ready[6]) s6_ff <= s6_in;
      if (stage_ready[7]) s7_ff <= s7_in;
      if (stage_ready[8]) s8_ff <= s8_in;
   end

   assign rsp_kind_a      = s8_ff.kind_a;
   assign rsp_kind_b      = s8_ff.kind_b;
   assign rsp_situation_a = s8_ff.sit_a;
   assign rsp_situation_b = s8_ff.sit_b;
   assign rsp_opposite    = s8_ff.opposite;
   assign rsp_place_a     = s8_ff.place_a;
   assign rsp_place_b     = s8_ff.place_b;

endmodule

>>> sv/cctc_checker.sv
// ----------------------------------------------------------------------------
// Crossing classifier checker
// Checks on the result word seen at the ports of the classifier.
// ----------------------------------------------------------------------------
module cctc_checker
   import cctc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_kind_a,
   input logic [1:0]         rsp_situation_a,
   input logic [1:0]         rsp_kind_b,
   input logic [1:0]         rsp_situation_b,
   input logic               rsp_opposite,
   input logic [PLACE_W-1:0] rsp_place_a,
   input logic [PLACE_W-1:0] rsp_place_b
);

   // A stalled result word holds.
   held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind_a) && $stable(rsp_kind_b)
         && $stable(rsp_situation_a) && $stable(rsp_situation_b)
         && $stable(rsp_opposite) && $stable(rsp_place_a) && $stable(rsp_place_b))
      else $error("result word changed while stalled");

   paired_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind_a == KIND_IN) == (rsp_kind_b == KIND_OUT))
         && ((rsp_kind_a == KIND_TOUCH) == (rsp_kind_b == KIND_TOUCH))
         && ((rsp_kind_a == KIND_UNDECIDED) == (rsp_kind_b == KIND_UNDECIDED)))
      else $error("kinds of the two curves do not pair");

   no_side_without_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind_a != KIND_TOUCH) |->
         (rsp_situation_a == SIT_UNKNOWN) && (rsp_situation_b == SIT_UNKNOWN) && !rsp_opposite)
      else $error("side or opposite flag given without touch");

   touch_sides: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind_a == KIND_TOUCH) && (rsp_situation_b != SIT_UNKNOWN) |->
         (rsp_situation_a != SIT_UNKNOWN)
         && ((rsp_situation_a == rsp_situation_b) == rsp_opposite))
      else $error("touch sides disagree with the opposite flag");

endmodule

bind curve_crossing_transition_classifier cctc_checker u_cctc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind_a      (rsp_kind_a),
   .rsp_situation_a (rsp_situation_a),
   .rsp_kind_b      (rsp_kind_b),
   .rsp_situation_b (rsp_situation_b),
   .rsp_opposite    (rsp_opposite),
   .rsp_place_a     (rsp_place_a),
   .rsp_place_b     (rsp_place_b)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Crossing transition classifier testbench
// Streams crossing points into the classifier and checks every result word
// against a transition predictor kept in step with the register writes.
// Covers null and replaced tangents, touching and crossing curves, the
// curvature tolerance and reserved positions, then exercises several
// register settings with random, mostly well-formed crossings and random
// idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import cctc_pkg::*;

   localparam int COMP_W = 24;
   localparam longint ONE_Q16 = 65536;
   localparam longint COMP_MAX_V = 8388607;
   localparam longint COMP_MIN_V = -8388608;
   localparam logic [PLACE_W-1:0] PLACE_HEAD = 2'd0;
   localparam logic [PLACE_W-1:0] PLACE_MIDDLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic [PLACE_W-1:0]       position_a;
      logic signed [COMP_W-1:0] tangent_a_x, tangent_a_y, normal_a_x, normal_a_y;
      logic [PLACE_W-1:0]       position_b;
      logic signed [COMP_W-1:0] tangent_b_x, tangent_b_y, normal_b_x, normal_b_y;
   } crossing_type;

   typedef struct {
      kind_type           kind_a;
      situation_type      situation_a;
      kind_type           kind_b;
      situation_type      situation_b;
      logic               opposite;
      logic [PLACE_W-1:0] place_a;
      logic [PLACE_W-1:0] place_b;
   } transition_type;

   class transition_ledger;
      longint         null_limit;
      longint         parallel_tol;
      longint         curvature_tol;
      transition_type awaited[$];
      int             errors;

      function new();
         null_limit = longint'(NULL_LIMIT_RESET);
         parallel_tol = longint'(PARALLEL_TOL_RESET);
         curvature_tol = longint'(CURVATURE_TOL_RESET);
         errors = 0;
      endfunction

      function void classify(crossing_type c);
         longint         t1x, t1y, t2x, t2y, m1, m2, cr, dt, va, vb, diff;
         logic [255:0]   lhs, rhs;
         bit             bend_a, bend_b, known;
         transition_type r;
         t1x = c.tangent_a_x;
         t1y = c.tangent_a_y;
         t2x = c.tangent_b_x;
         t2y = c.tangent_b_y;
         bend_a = 1'b1;
         bend_b = 1'b1;
         known = 1'b1;
         r.kind_a = KIND_UNDECIDED;
         r.kind_b = KIND_UNDECIDED;
         r.situation_a = SIT_UNKNOWN;
         r.situation_b = SIT_UNKNOWN;
         r.opposite = 1'b0;
         r.place_a = (c.position_a == PLACE_RESERVED) ? PLACE_END : c.position_a;
         r.place_b = (c.position_b == PLACE_RESERVED) ? PLACE_END : c.position_b;
         if (t1x * t1x + t1y * t1y <= null_limit) begin
            t1x = c.normal_a_x;
            t1y = c.normal_a_y;
            bend_a = 1'b0;
            if (t1x * t1x + t1y * t1y <= null_limit) known = 1'b0;
         end
         if (t2x * t2x + t2y * t2y <= null_limit) begin
            t2x = c.normal_b_x;
            t2y = c.normal_b_y;
            bend_b = 1'b0;
            if (t2x * t2x + t2y * t2y <= null_limit) known = 1'b0;
         end
         if (known) begin
            m1 = t1x * t1x + t1y * t1y;
            m2 = t2x * t2x + t2y * t2y;
            cr = t1x * t2y - t1y * t2x;
            lhs = (cr < 0) ? -cr : cr;
            lhs = lhs * lhs;
            rhs = parallel_tol;
            rhs = rhs * m1;
            rhs = rhs * m2;
            if (lhs <= (rhs >> 64)) begin
               dt = t1x * t2x + t1y * t2y;
               r.kind_a = KIND_TOUCH;
               r.kind_b = KIND_TOUCH;
               r.opposite = (dt < 0);
               va = bend_a ? t1x * c.normal_a_y - t1y * c.normal_a_x : 0;
               vb = bend_b ? t1x * c.normal_b_y - t1y * c.normal_b_x : 0;
               diff = va - vb;
               if (diff > curvature_tol || -diff > curvature_tol) begin
                  if (diff < 0) begin
                     r.situation_b = SIT_INSIDE;
                     r.situation_a = r.opposite ? SIT_INSIDE : SIT_OUTSIDE;
                  end else begin
                     r.situation_b = SIT_OUTSIDE;
                     r.situation_a = r.opposite ? SIT_OUTSIDE : SIT_INSIDE;
                  end
               end
            end else if (cr < 0) begin
               r.kind_a = KIND_IN;
               r.kind_b = KIND_OUT;
            end else begin
               r.kind_a = KIND_OUT;
               r.kind_b = KIND_IN;
            end
         end
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
         end
      endfunction

      function void compare_transition(transition_type got);
         transition_type want;
         if (awaited.size() == 0) begin
            $error("result word arrived with no transition awaited");
            errors++;
         end else begin
            want = awaited.pop_front();
            compare_field("kind_a", want.kind_a, got.kind_a);
            compare_field("situation_a", want.situation_a, got.situation_a);
            compare_field("kind_b", want.kind_b, got.kind_b);
            compare_field("situation_b", want.situation_b, got.situation_b);
            compare_field("opposite", want.opposite, got.opposite);
            compare_field("place_a", want.place_a, got.place_a);
            compare_field("place_b", want.place_b, got.place_b);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PLACE_W-1:0]       req_position_a = '0;
   logic signed [COMP_W-1:0] req_tangent_a_x = '0;
   logic signed [COMP_W-1:0] req_tangent_a_y = '0;
   logic signed [COMP_W-1:0] req_normal_a_x = '0;
   logic signed [COMP_W-1:0] req_normal_a_y = '0;
   logic [PLACE_W-1:0]       req_position_b = '0;
   logic signed [COMP_W-1:0] req_tangent_b_x = '0;
   logic signed [COMP_W-1:0] req_tangent_b_y = '0;
   logic signed [COMP_W-1:0] req_normal_b_x = '0;
   logic signed [COMP_W-1:0] req_normal_b_y = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_kind_a;
   logic [1:0]               rsp_situation_a;
   logic [1:0]               rsp_kind_b;
   logic [1:0]               rsp_situation_b;
   logic                     rsp_opposite;
   logic [PLACE_W-1:0]       rsp_place_a;
   logic [PLACE_W-1:0]       rsp_place_b;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]         csr_data = '0;

   transition_ledger ledger = new();
   int               gap_pct = 0;
   int               stall_left = 0;

   curve_crossing_transition_classifier #(.COMPONENT_BITS(COMP_W)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      transition_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind_a = kind_type'(rsp_kind_a);
         got.situation_a = situation_type'(rsp_situation_a);
         got.kind_b = kind_type'(rsp_kind_b);
         got.situation_b = situation_type'(rsp_situation_b);
         got.opposite = rsp_opposite;
         got.place_a = rsp_place_a;
         got.place_b = rsp_place_b;
         ledger.compare_transition(got);
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < gap_pct) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic signed [COMP_W-1:0] rand_component(int unsigned scale);
      longint span;
      span = longint'(1) << scale;
      return COMP_W'($urandom_range(0, 32'(2 * span - 1)) - span);
   endfunction

   function automatic logic signed [COMP_W-1:0] extreme_component();
      case ($urandom_range(0, 4))
         0: return COMP_W'(COMP_MIN_V);
         1: return COMP_W'(COMP_MAX_V);
         2: return '0;
         3: return COMP_W'(1);
         default: return '1;
      endcase
   endfunction

   function automatic crossing_type make_crossing(logic [PLACE_W-1:0] pa, longint tax,
                                                  longint tay, longint nax, longint nay,
                                                  logic [PLACE_W-1:0] pb, longint tbx,
                                                  longint tby, longint nbx, longint nby);
      crossing_type c;
      c.position_a = pa;
      c.tangent_a_x = COMP_W'(tax);
      c.tangent_a_y = COMP_W'(tay);
      c.normal_a_x = COMP_W'(nax);
      c.normal_a_y = COMP_W'(nay);
      c.position_b = pb;
      c.tangent_b_x = COMP_W'(tbx);
      c.tangent_b_y = COMP_W'(tby);
      c.normal_b_x = COMP_W'(nbx);
      c.normal_b_y = COMP_W'(nby);
      return c;
   endfunction

   task automatic send_crossing(crossing_type c);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_position_a <= c.position_a;
      req_tangent_a_x <= c.tangent_a_x;
      req_tangent_a_y <= c.tangent_a_y;
      req_normal_a_x <= c.normal_a_x;
      req_normal_a_y <= c.normal_a_y;
      req_position_b <= c.position_b;
      req_tangent_b_x <= c.tangent_b_x;
      req_tangent_b_y <= c.tangent_b_y;
      req_normal_b_x <= c.normal_b_x;
      req_normal_b_y <= c.normal_b_y;
      do @(posedge clock); while (!req_ready);
      ledger.classify(c);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NULL_LIMIT:    ledger.null_limit = longint'(value);
         CSR_PARALLEL_TOL:  ledger.parallel_tol = longint'(value);
         CSR_CURVATURE_TOL: ledger.curvature_tol = longint'(value);
         default: ;
      endcase
   endtask

   task automatic run_random_crossings(int count, int pct);
      crossing_type c;
      int           mode;
      int           s;
      longint       bx, by, k1, k2;
      gap_pct = pct;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 99);
         c.position_a = ($urandom_range(0, 19) == 0) ? PLACE_RESERVED
                                                     : PLACE_W'($urandom_range(0, PLACE_END));
         c.position_b = ($urandom_range(0, 19) == 0) ? PLACE_RESERVED
                                                     : PLACE_W'($urandom_range(0, PLACE_END));
         c.tangent_a_x = rand_component(23);
         c.tangent_a_y = rand_component(23);
         c.normal_a_x = rand_component(23);
         c.normal_a_y = rand_component(23);
         c.tangent_b_x = rand_component(23);
         c.tangent_b_y = rand_component(23);
         c.normal_b_x = rand_component(23);
         c.normal_b_y = rand_component(23);
         if (mode < 20) begin
         end else if (mode < 45) begin
            s = $urandom_range(0, 20);
            bx = rand_component(s);
            by = rand_component(s);
            k1 = $urandom_range(1, 3);
            k2 = $urandom_range(1, 3);
            if ($urandom_range(0, 1)) k1 = -k1;
            if ($urandom_range(0, 1)) k2 = -k2;
            c.tangent_a_x = COMP_W'(bx * k1);
            c.tangent_a_y = COMP_W'(by * k1);
            c.tangent_b_x = COMP_W'(bx * k2);
            c.tangent_b_y = COMP_W'(by * k2);
            s = $urandom_range(0, 23);
            c.normal_a_x = rand_component(s);
            c.normal_a_y = rand_component(s);
            case ($urandom_range(0, 3))
               0: begin
                  c.normal_b_x = c.normal_a_x;
                  c.normal_b_y = c.normal_a_y;
               end
               1: begin
                  c.normal_b_x = c.normal_a_x + rand_component($urandom_range(0, 6));
                  c.normal_b_y = c.normal_a_y + rand_component($urandom_range(0, 6));
               end
               2: begin
                  c.normal_b_x = rand_component(s);
                  c.normal_b_y = rand_component(s);
               end
               default: ;
            endcase
            if ($urandom_range(0, 7) == 0) begin
               c.tangent_a_x = '0;
               c.tangent_a_y = '0;
            end
            if ($urandom_range(0, 7) == 0) begin
               c.tangent_b_x = '0;
               c.tangent_b_y = '0;
            end
         end else if (mode < 65) begin
            s = $urandom_range(4, 21);
            bx = rand_component(s);
            by = rand_component(s);
            c.tangent_a_x = COMP_W'(bx);
            c.tangent_a_y = COMP_W'(by);
            c.tangent_b_x = COMP_W'(bx) + rand_component($urandom_range(0, 5));
            c.tangent_b_y = COMP_W'(by) + rand_component($urandom_range(0, 5));
            if ($urandom_range(0, 1)) begin
               c.tangent_b_x = -c.tangent_b_x;
               c.tangent_b_y = -c.tangent_b_y;
            end
         end else if (mode < 85) begin
            s = $urandom_range(0, 12);
            c.tangent_a_x = rand_component(s);
            c.tangent_a_y = rand_component(s);
            s = $urandom_range(0, 12);
            c.tangent_b_x = rand_component(s);
            c.tangent_b_y = rand_component(s);
            s = $urandom_range(0, 23);
            c.normal_a_x = rand_component(s);
            c.normal_a_y = rand_component(s);
            s = $urandom_range(0, 23);
            c.normal_b_x = rand_component(s);
            c.normal_b_y = rand_component(s);
         end else begin
            c.tangent_a_x = extreme_component();
            c.tangent_a_y = extreme_component();
            c.normal_a_x = extreme_component();
            c.normal_a_y = extreme_component();
            c.tangent_b_x = extreme_component();
            c.tangent_b_y = extreme_component();
            c.normal_b_x = extreme_component();
            c.normal_b_y = extreme_component();
         end
         send_crossing(c);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;
      send_crossing(make_crossing(PLACE_HEAD, 0, 0, 0, 0, PLACE_HEAD, 0, 0, 0, 0));
      send_crossing(make_crossing(PLACE_MIDDLE, ONE_Q16, 0, 0, 0,
                                  PLACE_END, 0, ONE_Q16, 0, 0));
      send_crossing(make_crossing(PLACE_END, 0, ONE_Q16, 0, 0,
                                  PLACE_MIDDLE, ONE_Q16, 0, 0, 0));
      send_crossing(make_crossing(PLACE_HEAD, ONE_Q16, 0, 0, ONE_Q16,
                                  PLACE_HEAD, 2 * ONE_Q16, 0, 0, 0));
      send_crossing(make_crossing(PLACE_MIDDLE, ONE_Q16, 0, 0, ONE_Q16,
                                  PLACE_MIDDLE, 2 * ONE_Q16, 0, 0, 2 * ONE_Q16));
      send_crossing(make_crossing(PLACE_END, ONE_Q16, 0, 0, ONE_Q16,
                                  PLACE_END, -ONE_Q16, 0, 0, 0));
      send_crossing(make_crossing(PLACE_HEAD, ONE_Q16, 0, 0, ONE_Q16,
                                  PLACE_MIDDLE, -ONE_Q16, 0, 0, 2 * ONE_Q16));
      send_crossing(make_crossing(PLACE_MIDDLE, ONE_Q16, 0, 0, ONE_Q16,
                                  PLACE_END, 3 * ONE_Q16, 0, 0, ONE_Q16));
      send_crossing(make_crossing(PLACE_END, 1, 0, 0, 43, PLACE_HEAD, 2, 0, 0, 0));
      send_crossing(make_crossing(PLACE_HEAD, 1, 0, 0, 44, PLACE_MIDDLE, 2, 0, 0, 0));
      send_crossing(make_crossing(PLACE_MIDDLE, 0, 0, ONE_Q16, 0,
                                  PLACE_END, 0, ONE_Q16, 0, 0));
      send_crossing(make_crossing(PLACE_END, 0, 0, 0, 0,
                                  PLACE_HEAD, ONE_Q16, ONE_Q16, ONE_Q16, 0));
      send_crossing(make_crossing(PLACE_HEAD, ONE_Q16, ONE_Q16, 0, ONE_Q16,
                                  PLACE_MIDDLE, 0, 0, 0, 0));
      send_crossing(make_crossing(PLACE_MIDDLE, 0, 0, ONE_Q16, 0,
                                  PLACE_END, 0, 0, -ONE_Q16, 0));
      send_crossing(make_crossing(PLACE_END, 0, 0, ONE_Q16, 0,
                                  PLACE_HEAD, ONE_Q16, 0, 0, ONE_Q16));
      send_crossing(make_crossing(PLACE_RESERVED, COMP_MIN_V, COMP_MIN_V, COMP_MAX_V,
                                  COMP_MIN_V, PLACE_RESERVED, COMP_MAX_V, COMP_MAX_V,
                                  COMP_MIN_V, COMP_MAX_V));
      send_crossing(make_crossing(PLACE_HEAD, COMP_MIN_V, COMP_MAX_V, COMP_MIN_V,
                                  COMP_MIN_V, PLACE_MIDDLE, COMP_MAX_V, COMP_MIN_V,
                                  COMP_MAX_V, COMP_MAX_V));
      send_crossing(make_crossing(PLACE_RESERVED, COMP_MAX_V, 0, COMP_MAX_V, COMP_MAX_V,
                                  PLACE_END, COMP_MAX_V, 1, COMP_MIN_V, 0));
      send_crossing(make_crossing(PLACE_MIDDLE, COMP_MAX_V, COMP_MAX_V, COMP_MAX_V,
                                  COMP_MAX_V, PLACE_RESERVED, COMP_MIN_V, COMP_MIN_V,
                                  COMP_MIN_V, COMP_MIN_V));
      req_valid <= 1'b0;

      write_register(CSR_NULL_LIMIT, 32'h0001_0000);
      write_register(CSR_PARALLEL_TOL, 32'h0010_0000);
      write_register(CSR_CURVATURE_TOL, 32'd1000);
      run_random_crossings(300, 25);

      write_register(CSR_NULL_LIMIT, 32'hFFFF_FFFF);
      write_register(CSR_PARALLEL_TOL, 32'hFFFF_FFFF);
      write_register(CSR_CURVATURE_TOL, 32'hFFFF_FFFF);
      run_random_crossings(200, 40);

      write_register(CSR_NULL_LIMIT, '0);
      write_register(CSR_PARALLEL_TOL, '0);
      write_register(CSR_CURVATURE_TOL, '0);
      run_random_crossings(200, 10);

      write_register(CSR_UNUSED, $urandom);
      write_register(CSR_NULL_LIMIT, $urandom >> $urandom_range(0, 31));
      write_register(CSR_PARALLEL_TOL, $urandom >> $urandom_range(0, 31));
      write_register(CSR_CURVATURE_TOL, $urandom >> $urandom_range(0, 31));
      run_random_crossings(300, 25);

      // The closing stretch runs at full rate with the reset settings restored.
      write_register(CSR_NULL_LIMIT, NULL_LIMIT_RESET);
      write_register(CSR_PARALLEL_TOL, PARALLEL_TOL_RESET);
      write_register(CSR_CURVATURE_TOL, CURVATURE_TOL_RESET);
      run_random_crossings(200, 0);

      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
